[sv/tihi_pkg.sv]
// Package for the time indexed history interpolator.
// Holds the sample entry type, controller/datapath command and status types and constants.
// No dependencies.
`default_nettype none
package tihi_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int CUT_W      = 7;
	localparam int TDS_W      = 32;
	localparam int TDS_RESET  = 250000;
	localparam int ONE_MS     = 16;
	localparam int DIV_LAST   = 15;
	localparam int TELE_LAST  = 2;
	localparam int LERP_LAST  = 10;
	localparam int ALPHA_HALF = 32768;

	typedef struct packed {
		logic signed [31:0] tm;
		logic signed [31:0] lx;
		logic signed [31:0] ly;
		logic signed [31:0] lz;
		logic [30:0]        ex;
		logic [30:0]        ey;
		logic [30:0]        ez;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
		logic signed [31:0] roll;
		logic               rew;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_APPEND,
		OP_START,
		OP_EMPTY,
		OP_RD_F,
		OP_RD_L,
		OP_RD_C,
		OP_DECIDE,
		OP_S_ISS,
		OP_S_CMP,
		OP_RD_P,
		OP_RD_N,
		OP_CAP_N,
		OP_PREP,
		OP_NORM,
		OP_DIV,
		OP_TELE,
		OP_LERP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic       empty;
		logic       interp;
		logic       search_done;
		logic [3:0] k;
	} status_t;

	typedef enum logic {
		REG_CUTOFF   = 1'b0,
		REG_TELEPORT = 1'b1
	} reg_idx_t;

endpackage
`default_nettype wire

[sv/tihi_ctrl.sv]
// Controller state machine of the history interpolator.
// Sequences appends and queries through the datapath; uses tihi_pkg.
`default_nettype none
module tihi_ctrl
	import tihi_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    mode,
	input  wire logic    out_stall,
	input  wire status_t st,
	output cmd_t         cmd,
	output logic         in_stall,
	output logic         out_valid
);

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_RDF  = 16'h0002,
		S_RDL  = 16'h0004,
		S_RDC  = 16'h0008,
		S_DEC  = 16'h0010,
		S_SISS = 16'h0020,
		S_SCMP = 16'h0040,
		S_RDP  = 16'h0080,
		S_RDN  = 16'h0100,
		S_CAPN = 16'h0200,
		S_PREP = 16'h0400,
		S_NORM = 16'h0800,
		S_DIV  = 16'h1000,
		S_TELE = 16'h2000,
		S_LERP = 16'h4000,
		S_OUT  = 16'h8000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!mode) begin
						cmd.op = OP_APPEND;
					end else if (st.empty) begin
						cmd.op  = OP_EMPTY;
						state_d = S_OUT;
					end else begin
						cmd.op  = OP_START;
						state_d = S_RDF;
					end
				end
			end
			S_RDF: begin
				cmd.op  = OP_RD_F;
				state_d = S_RDL;
			end
			S_RDL: begin
				cmd.op  = OP_RD_L;
				state_d = S_RDC;
			end
			S_RDC: begin
				cmd.op  = OP_RD_C;
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.op  = OP_DECIDE;
				state_d = st.interp ? S_SISS : S_OUT;
			end
			S_SISS: begin
				cmd.op  = OP_S_ISS;
				state_d = st.search_done ? S_RDP : S_SCMP;
			end
			S_SCMP: begin
				cmd.op  = OP_S_CMP;
				state_d = S_SISS;
			end
			S_RDP: begin
				cmd.op  = OP_RD_P;
				state_d = S_RDN;
			end
			S_RDN: begin
				cmd.op  = OP_RD_N;
				state_d = S_CAPN;
			end
			S_CAPN: begin
				cmd.op  = OP_CAP_N;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				state_d = S_NORM;
			end
			S_NORM: begin
				cmd.op  = OP_NORM;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (st.k == 4'(DIV_LAST)) state_d = S_TELE;
			end
			S_TELE: begin
				cmd.op = OP_TELE;
				if (st.k == 4'(TELE_LAST)) state_d = S_LERP;
			end
			S_LERP: begin
				cmd.op = OP_LERP;
				if (st.k == 4'(LERP_LAST)) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule
`default_nettype wire

[sv/tihi_dp.sv]
// Datapath of the history interpolator: sample memory, search, divider and lerp unit.
// Driven by tihi_ctrl through cmd_t; uses tihi_pkg.
`default_nettype none
module tihi_dp
	import tihi_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output status_t                  st,
	input  wire logic [CUT_W-1:0]    cutoff_index,
	input  wire logic [TDS_W-1:0]    teleport_distance_sq,
	input  wire logic signed [31:0]  sample_time,
	input  wire logic signed [31:0]  loc_x,
	input  wire logic signed [31:0]  loc_y,
	input  wire logic signed [31:0]  loc_z,
	input  wire logic [30:0]         ext_x,
	input  wire logic [30:0]         ext_y,
	input  wire logic [30:0]         ext_z,
	input  wire logic signed [31:0]  rot_pitch,
	input  wire logic signed [31:0]  rot_yaw,
	input  wire logic signed [31:0]  rot_roll,
	input  wire logic                may_rewind,
	output logic                     found,
	output logic signed [31:0]       out_time,
	output logic signed [31:0]       out_loc_x,
	output logic signed [31:0]       out_loc_y,
	output logic signed [31:0]       out_loc_z,
	output logic [30:0]              out_ext_x,
	output logic [30:0]              out_ext_y,
	output logic [30:0]              out_ext_z,
	output logic signed [31:0]       out_pitch,
	output logic signed [31:0]       out_yaw,
	output logic signed [31:0]       out_roll,
	output logic                     out_may_rewind
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	entry_t mem [HISTORY_DEPTH];
	entry_t rdata_q, first_q, last_q, p_q, n_q, wentry;

	logic [AW-1:0] oldest_q, raddr, waddr;
	logic [CW-1:0] count_q, lo_q, cnt_q, half, mid;
	logic signed [31:0] t_q, c_q;
	logic signed [33:0] num_q, den_q;
	logic [33:0] rem_q, rem2;
	logic [16:0] alpha_q;
	logic        triv_q, tele_q;
	logic [44:0] sum_q;
	logic [3:0]  k_q;

	logic signed [50:0] prod_s1;
	logic signed [32:0] a_s1;
	logic [3:0]         idx_s1;
	logic               v_s1;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] x);
		logic [CW:0] s;
		s = {1'b0, x} + (CW+1)'(base);
		if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
		return s[AW-1:0];
	endfunction

	assign half = cnt_q >> 1;
	assign mid  = lo_q + half;

	// Query decision on the three end entries; rdata_q holds the cutoff entry here.
	logic        cut_hit, near_new, near_old, flat, interp;
	logic signed [33:0] t_ext;
	logic signed [31:0] c_new;
	entry_t      pick;

	always_comb begin
		t_ext    = 34'(t_q);
		cut_hit  = ((CUT_W+CW)'(cutoff_index) < (CUT_W+CW)'(count_q)) && (t_q < rdata_q.tm);
		near_new = t_ext >= (34'(last_q.tm) - 34'(ONE_MS));
		near_old = t_ext <= (34'(first_q.tm) + 34'(ONE_MS));
		flat     = (count_q < CW'(2)) || (first_q.tm == last_q.tm);
		interp   = 1'b0;
		if (cut_hit)       pick = rdata_q;
		else if (near_new) pick = last_q;
		else if (near_old) pick = first_q;
		else begin
			pick   = last_q;
			interp = !flat;
		end
		if (t_q < first_q.tm)     c_new = first_q.tm;
		else if (t_q < last_q.tm) c_new = t_q;
		else                      c_new = last_q.tm;
	end

	assign st.empty       = (count_q == '0);
	assign st.interp      = interp;
	assign st.search_done = (cnt_q == '0);
	assign st.k           = k_q;

	always_comb begin
		case (cmd.op)
			OP_RD_F:  raddr = phys(oldest_q, '0);
			OP_RD_L:  raddr = phys(oldest_q, count_q - CW'(1));
			OP_RD_C:  raddr = phys(oldest_q, CW'(cutoff_index));
			OP_S_ISS: raddr = phys(oldest_q, mid);
			OP_RD_P:  raddr = phys(oldest_q, lo_q - CW'(1));
			OP_RD_N:  raddr = phys(oldest_q, lo_q);
			default:  raddr = oldest_q;
		endcase
	end

	assign waddr = (count_q < CW'(HISTORY_DEPTH)) ? phys(oldest_q, count_q) : oldest_q;

	always_comb begin
		wentry.tm    = sample_time;
		wentry.lx    = loc_x;
		wentry.ly    = loc_y;
		wentry.lz    = loc_z;
		wentry.ex    = ext_x;
		wentry.ey    = ext_y;
		wentry.ez    = ext_z;
		wentry.pitch = rot_pitch;
		wentry.yaw   = rot_yaw;
		wentry.roll  = rot_roll;
		wentry.rew   = may_rewind;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND) mem[waddr] <= wentry;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (cmd.op == OP_APPEND) begin
			if (count_q < CW'(HISTORY_DEPTH)) count_q <= count_q + CW'(1);
			else                              oldest_q <= phys(oldest_q, CW'(1));
		end
	end

	// Location delta for the teleport test, one axis per cycle.
	logic signed [32:0] d;
	logic [32:0]        m;
	logic [41:0]        sq;
	always_comb begin
		case (k_q[1:0])
			2'd0:    d = 33'(n_q.lx) - 33'(p_q.lx);
			2'd1:    d = 33'(n_q.ly) - 33'(p_q.ly);
			default: d = 33'(n_q.lz) - 33'(p_q.lz);
		endcase
		m  = d[32] ? 33'(-d) : 33'(d);
		sq = m[20:0] * m[20:0];
	end

	// Lerp operand select, one field per cycle.
	logic signed [32:0] la, lb, ldiff;
	always_comb begin
		case (k_q)
			4'd0:    begin la = 33'(p_q.lx);    lb = 33'(n_q.lx);    end
			4'd1:    begin la = 33'(p_q.ly);    lb = 33'(n_q.ly);    end
			4'd2:    begin la = 33'(p_q.lz);    lb = 33'(n_q.lz);    end
			4'd3:    begin la = {2'b0, p_q.ex}; lb = {2'b0, n_q.ex}; end
			4'd4:    begin la = {2'b0, p_q.ey}; lb = {2'b0, n_q.ey}; end
			4'd5:    begin la = {2'b0, p_q.ez}; lb = {2'b0, n_q.ez}; end
			4'd6:    begin la = 33'(p_q.pitch); lb = 33'(n_q.pitch); end
			4'd7:    begin la = 33'(p_q.yaw);   lb = 33'(n_q.yaw);   end
			default: begin la = 33'(p_q.roll);  lb = 33'(n_q.roll);  end
		endcase
		ldiff = lb - la;
	end

	logic signed [50:0] lsum;
	logic [31:0]        lres;
	logic               teleport;
	assign lsum     = 51'(a_s1) + (prod_s1 >>> 16);
	assign lres     = lsum[31:0];
	assign teleport = tele_q || (sum_q > 45'({teleport_distance_sq, 8'h00}));
	assign rem2     = {rem_q[32:0], 1'b0};

	logic signed [33:0] nn, dd;
	always_comb begin
		nn = num_q;
		dd = den_q;
		if (den_q < 0) begin
			nn = -num_q;
			dd = -den_q;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= (cmd.op == OP_LERP) && (k_q < 4'(LERP_LAST));
		case (cmd.op)
			OP_START: t_q <= sample_time;
			OP_RD_L:  first_q <= rdata_q;
			OP_RD_C:  last_q <= rdata_q;
			OP_EMPTY: begin
				found          <= 1'b0;
				out_time       <= '0;
				out_loc_x      <= '0;
				out_loc_y      <= '0;
				out_loc_z      <= '0;
				out_ext_x      <= '0;
				out_ext_y      <= '0;
				out_ext_z      <= '0;
				out_pitch      <= '0;
				out_yaw        <= '0;
				out_roll       <= '0;
				out_may_rewind <= 1'b0;
			end
			OP_DECIDE: begin
				found          <= 1'b1;
				out_time       <= pick.tm;
				out_loc_x      <= pick.lx;
				out_loc_y      <= pick.ly;
				out_loc_z      <= pick.lz;
				out_ext_x      <= pick.ex;
				out_ext_y      <= pick.ey;
				out_ext_z      <= pick.ez;
				out_pitch      <= pick.pitch;
				out_yaw        <= pick.yaw;
				out_roll       <= pick.roll;
				out_may_rewind <= pick.rew;
				c_q            <= c_new;
				lo_q           <= CW'(1);
				cnt_q          <= count_q - CW'(2);
			end
			OP_S_CMP: begin
				if (c_q > rdata_q.tm) begin
					lo_q  <= mid + CW'(1);
					cnt_q <= cnt_q - half - CW'(1);
				end else begin
					cnt_q <= half;
				end
			end
			OP_RD_N:  p_q <= rdata_q;
			OP_CAP_N: n_q <= rdata_q;
			OP_PREP: begin
				num_q <= 34'(c_q) - 34'(p_q.tm);
				den_q <= 34'(n_q.tm) - 34'(p_q.tm);
			end
			OP_NORM: begin
				k_q    <= '0;
				sum_q  <= '0;
				tele_q <= 1'b0;
				den_q  <= dd;
				rem_q  <= nn;
				if (dd == 0 || nn <= 0) begin
					triv_q  <= 1'b1;
					alpha_q <= '0;
				end else if (nn >= dd) begin
					triv_q  <= 1'b1;
					alpha_q <= 17'h10000;
				end else begin
					triv_q  <= 1'b0;
					alpha_q <= '0;
				end
			end
			OP_DIV: begin
				k_q <= (k_q == 4'(DIV_LAST)) ? 4'd0 : k_q + 4'd1;
				if (!triv_q) begin
					if (rem2 >= den_q) begin
						rem_q   <= rem2 - den_q;
						alpha_q <= {alpha_q[15:0], 1'b1};
					end else begin
						rem_q   <= rem2;
						alpha_q <= {alpha_q[15:0], 1'b0};
					end
				end
			end
			OP_TELE: begin
				k_q <= (k_q == 4'(TELE_LAST)) ? 4'd0 : k_q + 4'd1;
				if (m[32:21] != '0) tele_q <= 1'b1;
				else                sum_q  <= sum_q + 45'(sq);
			end
			OP_LERP: begin
				k_q <= k_q + 4'd1;
				if (k_q < 4'(LERP_LAST)) begin
					prod_s1 <= 51'(ldiff) * 51'($signed({1'b0, alpha_q}));
					a_s1    <= la;
					idx_s1  <= k_q;
				end
				found          <= 1'b1;
				out_time       <= t_q;
				out_may_rewind <= (alpha_q > 17'(ALPHA_HALF)) ? n_q.rew : p_q.rew;
				if (v_s1) begin
					case (idx_s1)
						4'd0:    out_loc_x <= teleport ? n_q.lx : lres;
						4'd1:    out_loc_y <= teleport ? n_q.ly : lres;
						4'd2:    out_loc_z <= teleport ? n_q.lz : lres;
						4'd3:    out_ext_x <= lres[30:0];
						4'd4:    out_ext_y <= lres[30:0];
						4'd5:    out_ext_z <= lres[30:0];
						4'd6:    out_pitch <= lres;
						4'd7:    out_yaw   <= lres;
						default: out_roll  <= lres;
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sv/time_indexed_history_interpolator_core.sv]
// Top level of the time indexed history interpolator: APB register file plus
// controller and datapath. Depends on tihi_pkg, tihi_ctrl and tihi_dp.
//
//  channel | handshake               | beat contents
//  in      | in_valid / in_stall     | mode, sample_time, loc, ext, rot, may_rewind
//  out     | out_valid / out_stall   | found, out_time, out_loc, out_ext, out_rot, rewind
//  cfg     | APB psel/penable/pready | cutoff_index at 0x0, teleport_distance_sq at 0x4
//
// An append beat is taken without holding the input. An interpolating query passes through
// acceptance, the end reads and decision, a binary search of issue and compare steps that
// ends in a final issue, the neighbor fetch and divider setup, the serial alpha divider,
// the teleport test, the shared lerp multiplier and the result beat. A query answered by an
// end or cutoff entry skips the search, divider, teleport test and lerp; an empty query goes
// straight to its result beat. One item is in flight at a time; in_stall stays high from an
// accepted query until its result beat leaves, so output stalls hold off the next item.
// Reset empties the history; the sample memory itself is not cleared.
`default_nettype none
module time_indexed_history_interpolator_core
	import tihi_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic signed [31:0] sample_time,
	input  wire logic signed [31:0] loc_x,
	input  wire logic signed [31:0] loc_y,
	input  wire logic signed [31:0] loc_z,
	input  wire logic [30:0]        ext_x,
	input  wire logic [30:0]        ext_y,
	input  wire logic [30:0]        ext_z,
	input  wire logic signed [31:0] rot_pitch,
	input  wire logic signed [31:0] rot_yaw,
	input  wire logic signed [31:0] rot_roll,
	input  wire logic               may_rewind,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	output logic signed [31:0]      out_time,
	output logic signed [31:0]      out_loc_x,
	output logic signed [31:0]      out_loc_y,
	output logic signed [31:0]      out_loc_z,
	output logic [30:0]             out_ext_x,
	output logic [30:0]             out_ext_y,
	output logic [30:0]             out_ext_z,
	output logic signed [31:0]      out_pitch,
	output logic signed [31:0]      out_yaw,
	output logic signed [31:0]      out_roll,
	output logic                    out_may_rewind
);

	logic [CUT_W-1:0] cutoff_q;
	logic [TDS_W-1:0] tds_q;
	reg_idx_t         reg_sel;
	cmd_t             cmd;
	status_t          st;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUT_W'(HISTORY_DEPTH);
			tds_q    <= TDS_W'(TDS_RESET);
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_CUTOFF:   cutoff_q <= pwdata[CUT_W-1:0];
				REG_TELEPORT: tds_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CUTOFF:   prdata = 32'(cutoff_q);
			REG_TELEPORT: prdata = tds_q;
			default:      prdata = '0;
		endcase
	end

	tihi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	tihi_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.st                   (st),
		.cutoff_index         (cutoff_q),
		.teleport_distance_sq (tds_q),
		.sample_time          (sample_time),
		.loc_x                (loc_x),
		.loc_y                (loc_y),
		.loc_z                (loc_z),
		.ext_x                (ext_x),
		.ext_y                (ext_y),
		.ext_z                (ext_z),
		.rot_pitch            (rot_pitch),
		.rot_yaw              (rot_yaw),
		.rot_roll             (rot_roll),
		.may_rewind           (may_rewind),
		.found                (found),
		.out_time             (out_time),
		.out_loc_x            (out_loc_x),
		.out_loc_y            (out_loc_y),
		.out_loc_z            (out_loc_z),
		.out_ext_x            (out_ext_x),
		.out_ext_y            (out_ext_y),
		.out_ext_z            (out_ext_z),
		.out_pitch            (out_pitch),
		.out_yaw              (out_yaw),
		.out_roll             (out_roll),
		.out_may_rewind       (out_may_rewind)
	);

endmodule
`default_nettype wire

[sv/tihi_checker.sv]
// Port-level checker for the history interpolator, bound to the top level.
// Depends only on the ports of time_indexed_history_interpolator_core.
`default_nettype none
module tihi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic mode,
	input wire logic out_valid,
	input wire logic out_stall
);

	// A waiting result beat stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// No new item is taken while a result is pending.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// An append causes no result and frees the input at once.
	a_append_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode |=> !out_valid && !in_stall)
		else $error("append produced a result or stalled");

	// A delivered result is not repeated.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result beat repeated");

endmodule

bind time_indexed_history_interpolator_core tihi_checker u_tihi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
`default_nettype wire

[tb/tb_time_indexed_history_interpolator_core.sv]
// Testbench for time_indexed_history_interpolator_core: a directed table, then random
// phases under several register settings, checked against an in-bench pose predictor
// (typed table rows against their listed result). Depends on tihi_pkg and the core RTL.
`default_nettype none
module tb_time_indexed_history_interpolator_core;
	import tihi_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		bit     mode;
		entry_t e;
	} beat_t;

	typedef struct {
		bit     found;
		entry_t e;
	} pose_t;

	typedef struct {
		beat_t b;
		bit    typed;
		pose_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic pready;
	logic in_valid = 1'b0;
	wire logic in_stall;
	logic mode = 1'b0;
	logic signed [31:0] sample_time = '0, loc_x = '0, loc_y = '0, loc_z = '0;
	logic [30:0] ext_x = '0, ext_y = '0, ext_z = '0;
	logic signed [31:0] rot_pitch = '0, rot_yaw = '0, rot_roll = '0;
	logic may_rewind = 1'b0;
	wire logic out_valid;
	logic out_stall = 1'b0;
	wire logic found;
	wire logic signed [31:0] out_time, out_loc_x, out_loc_y, out_loc_z;
	wire logic [30:0] out_ext_x, out_ext_y, out_ext_z;
	wire logic signed [31:0] out_pitch, out_yaw, out_roll;
	wire logic out_may_rewind;

	time_indexed_history_interpolator_core uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state.
	entry_t hist [DEPTH];
	int unsigned oldest, count;
	int unsigned cut_reg;
	longint unsigned tds_reg;

	pose_t pending_poses [$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit calm = 0;
	int unsigned hold_req = 0;

	// Query times in ms for the directed table.
	int query_ms [9] = '{150, 275, 320, 350, 399, 480, 500, 101, 250};

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report(string what, longint got, longint want);
		if (got != want) begin
			errors++;
			$display("mismatch %s: got %h expected %h", what, got, want);
		end
	endtask

	function automatic int unsigned slot(int unsigned i);
		return (oldest + i) % DEPTH;
	endfunction

	function automatic longint lerp_q16(longint a, longint b, longint alpha);
		return a + (((b - a) * alpha) >>> 16);
	endfunction

	function automatic bit jumps(int unsigned a, int unsigned b);
		longint d [3];
		longint unsigned m, sum;
		sum = 0;
		d[0] = longint'(hist[b].lx) - longint'(hist[a].lx);
		d[1] = longint'(hist[b].ly) - longint'(hist[a].ly);
		d[2] = longint'(hist[b].lz) - longint'(hist[a].lz);
		for (int k = 0; k < 3; k++) begin
			m = d[k] < 0 ? -d[k] : d[k];
			if (m >= (64'd1 << 21)) return 1;
			sum += m * m;
		end
		return sum > tds_reg * 256;
	endfunction

	function automatic void predict_pose(input beat_t b, output pose_t r, output bit has);
		int unsigned w, last, pf, pl, pc, lo, cnt, half, mid, pn, pp;
		longint t, tmin, tmax, c, num, den, alpha;
		r.found = 0;
		r.e = '0;
		has = 0;
		if (!b.mode) begin
			if (count < DEPTH) begin
				w = slot(count);
				count++;
			end else begin
				w = oldest;
				oldest = slot(1);
			end
			hist[w] = b.e;
			return;
		end
		has = 1;
		if (count == 0) return;
		t = b.e.tm;
		last = count - 1;
		pf = slot(0);
		pl = slot(last);
		tmin = hist[pf].tm;
		tmax = hist[pl].tm;
		r.found = 1;
		if (cut_reg < count) begin
			pc = slot(cut_reg);
			if (t < longint'(hist[pc].tm)) begin
				r.e = hist[pc];
				return;
			end
		end
		if (t >= tmax - ONE_MS) begin
			r.e = hist[pl];
			return;
		end
		if (t <= tmin + ONE_MS) begin
			r.e = hist[pf];
			return;
		end
		c = t < tmin ? tmin : (t < tmax ? t : tmax);
		if (count < 2 || tmin == tmax) begin
			r.e = hist[pl];
			return;
		end
		lo = 1;
		cnt = last - 1;
		while (cnt > 0) begin
			half = cnt / 2;
			mid = lo + half;
			if (c > longint'(hist[slot(mid)].tm)) begin
				lo = mid + 1;
				cnt -= half + 1;
			end else begin
				cnt = half;
			end
		end
		pn = slot(lo);
		pp = slot(lo - 1);
		num = c - longint'(hist[pp].tm);
		den = longint'(hist[pn].tm) - longint'(hist[pp].tm);
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (den == 0 || num <= 0) alpha = 0;
		else if (num >= den) alpha = 65536;
		else alpha = (num <<< 16) / den;
		r.e.tm = b.e.tm;
		if (jumps(pp, pn)) begin
			r.e.lx = hist[pn].lx;
			r.e.ly = hist[pn].ly;
			r.e.lz = hist[pn].lz;
		end else begin
			r.e.lx = lerp_q16(hist[pp].lx, hist[pn].lx, alpha);
			r.e.ly = lerp_q16(hist[pp].ly, hist[pn].ly, alpha);
			r.e.lz = lerp_q16(hist[pp].lz, hist[pn].lz, alpha);
		end
		r.e.ex = lerp_q16(hist[pp].ex, hist[pn].ex, alpha);
		r.e.ey = lerp_q16(hist[pp].ey, hist[pn].ey, alpha);
		r.e.ez = lerp_q16(hist[pp].ez, hist[pn].ez, alpha);
		r.e.pitch = lerp_q16(hist[pp].pitch, hist[pn].pitch, alpha);
		r.e.yaw = lerp_q16(hist[pp].yaw, hist[pn].yaw, alpha);
		r.e.roll = lerp_q16(hist[pp].roll, hist[pn].roll, alpha);
		r.e.rew = alpha > ALPHA_HALF ? hist[pn].rew : hist[pp].rew;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
	int unsigned stall_left = 0;
	int unsigned hold_seen = 0;
	always @(posedge clk) begin
		pose_t want;
		if (out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				report("unexpected result beat", 1, 0);
			end else begin
				want = pending_poses.pop_front();
				report("found", found, want.found);
				report("time", out_time, want.e.tm);
				report("loc_x", out_loc_x, want.e.lx);
				report("loc_y", out_loc_y, want.e.ly);
				report("loc_z", out_loc_z, want.e.lz);
				report("ext_x", out_ext_x, want.e.ex);
				report("ext_y", out_ext_y, want.e.ey);
				report("ext_z", out_ext_z, want.e.ez);
				report("pitch", out_pitch, want.e.pitch);
				report("yaw", out_yaw, want.e.yaw);
				report("roll", out_roll, want.e.roll);
				report("may_rewind", out_may_rewind, want.e.rew);
			end
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			stall_left = 400;
		end else if (stall_left == 0) begin
			stall_left = gap_len();
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_beat(beat_t b, bit typed, pose_t tr);
		pose_t pr;
		bit has;
		int unsigned g;
		mode <= b.mode;
		sample_time <= b.e.tm;
		loc_x <= b.e.lx;
		loc_y <= b.e.ly;
		loc_z <= b.e.lz;
		ext_x <= b.e.ex;
		ext_y <= b.e.ey;
		ext_z <= b.e.ez;
		rot_pitch <= b.e.pitch;
		rot_yaw <= b.e.yaw;
		rot_roll <= b.e.roll;
		may_rewind <= b.e.rew;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_pose(b, pr, has);
		if (has) pending_poses.push_back(typed ? tr : pr);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_CUTOFF) cut_reg = value[CUT_W-1:0];
		else tds_reg = value;
	endtask

	task automatic drain();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic entry_t rand_entry();
		entry_t e;
		e.tm = $urandom;
		e.lx = $urandom;
		e.ly = $urandom;
		e.lz = $urandom;
		e.ex = $urandom;
		e.ey = $urandom;
		e.ez = $urandom;
		e.pitch = $urandom;
		e.yaw = $urandom;
		e.roll = $urandom;
		e.rew = $urandom;
		return e;
	endfunction

	// Mostly ordered appends with small motion, queries around the held time range,
	// and a share of fully random beats as noise.
	function automatic beat_t rand_beat();
		beat_t b;
		entry_t prev;
		int unsigned r;
		longint lo_t, hi_t;
		b.e = rand_entry();
		b.mode = $urandom_range(0, 99) < 55;
		r = $urandom_range(0, 99);
		if (r < 8 || count == 0) return b;
		prev = hist[slot(count - 1)];
		if (!b.mode) begin
			if (r < 15) b.e.tm = prev.tm - $urandom_range(0, 200);
			else if (r < 20) b.e.tm = prev.tm;
			else b.e.tm = prev.tm + $urandom_range(1, 1024);
			if (r < 85) begin
				b.e.lx = prev.lx + $signed($urandom_range(0, 8000)) - 4000;
				b.e.ly = prev.ly + $signed($urandom_range(0, 8000)) - 4000;
				b.e.lz = prev.lz + $signed($urandom_range(0, 8000)) - 4000;
			end else if (r < 95) begin
				b.e.lx = prev.lx + $signed($urandom_range(0, 40000)) - 20000;
			end
		end else begin
			lo_t = hist[slot(0)].tm;
			hi_t = prev.tm;
			if (hi_t < lo_t) begin
				lo_t = prev.tm;
				hi_t = hist[slot(0)].tm;
			end
			b.e.tm = lo_t - 64 + longint'($urandom) % (hi_t - lo_t + 129);
		end
		return b;
	endfunction

	row_t rows [$];

	initial begin
		row_t row;
		entry_t big;
		pose_t none;
		none.found = 0;
		none.e = '0;
		cut_reg = DEPTH;
		tds_reg = TDS_RESET;
		oldest = 0;
		count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_write(REG_CUTOFF, DEPTH);
		apb_write(REG_TELEPORT, TDS_RESET);

		big.tm = 100 * 16;
		big.lx = 32'h7FFFFFFF;
		big.ly = 32'h80000000;
		big.lz = 0;
		big.ex = 31'h7FFFFFFF;
		big.ey = 31'h7FFFFFFF;
		big.ez = 31'h7FFFFFFF;
		big.pitch = 32'h80000000;
		big.yaw = 32'h7FFFFFFF;
		big.roll = -1;
		big.rew = 1;
		// Empty history gives not found with all zero fields.
		row.b.mode = 1; row.b.e = '0; row.b.e.tm = 32'h7FFFFFFF;
		row.typed = 1; row.r = none; rows.push_back(row);
		row.b.mode = 0; row.b.e = big; row.typed = 0; rows.push_back(row);
		// A single sample is returned at either extreme of time.
		row.b.mode = 1; row.b.e = '0; row.b.e.tm = 32'h80000000;
		row.typed = 1; row.r.found = 1; row.r.e = big; rows.push_back(row);
		row.b.e.tm = 32'h7FFFFFFF; rows.push_back(row);
		row.b.e.tm = 100 * 16 + 8; rows.push_back(row);
		row.typed = 0;
		for (int i = 2; i <= 5; i++) begin
			row.b.mode = 0; row.b.e = '0; row.b.e.tm = i * 100 * 16;
			row.b.e.lx = i * 160; row.b.e.ex = i * 32; row.b.e.yaw = -i * 500;
			row.b.e.rew = i[0];
			if (i == 4) row.b.e.lx = 32'h40000000;
			rows.push_back(row);
		end
		foreach (query_ms[k]) begin
			row.b.mode = 1; row.b.e = '0;
			row.b.e.tm = query_ms[k] * 16;
			rows.push_back(row);
		end
		// An out of order sample, then queries across it.
		row.b.mode = 0; row.b.e = '0; row.b.e.tm = 50 * 16; row.b.e.ly = -3000;
		rows.push_back(row);
		row.b.mode = 1; row.b.e.tm = 450 * 16; rows.push_back(row);
		row.b.e.tm = 520 * 16; rows.push_back(row);
		row.b.e.tm = 90 * 16; rows.push_back(row);
		foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].r);
		in_valid <= 1'b0;
		@(posedge clk);

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			case (ph)
				0: begin apb_write(REG_CUTOFF, 1); apb_write(REG_TELEPORT, 0); end
				1: begin apb_write(REG_CUTOFF, 0); apb_write(REG_TELEPORT, 32'hFFFFFFFF); end
				2: begin apb_write(REG_CUTOFF, DEPTH); apb_write(REG_TELEPORT, TDS_RESET); end
				3: begin apb_write(REG_CUTOFF, 63); apb_write(REG_TELEPORT, 10000); end
				default: begin
					apb_write(REG_CUTOFF, $urandom_range(0, DEPTH));
					apb_write(REG_TELEPORT, $urandom_range(0, 1000000));
				end
			endcase
			calm = (ph == 3);
			for (int i = 0; i < 225; i++) begin
				if (ph == 2 && i == 30) hold_req++;
				send_beat(rand_beat(), 0, none);
			end
			in_valid <= 1'b0;
			@(posedge clk);
		end
		calm = 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
